### rtl/sapa_pkg.sv
package sapa_pkg;

    localparam int MAX_HOST_BITS_DEF = 8;
    localparam int ADDR_W            = 32;
    localparam int PREFIX_W          = 5;
    localparam int STATUS_W          = 3;
    localparam int FREE_W            = 8;
    localparam int OUT_TDATA_W       = 40;
    localparam int CFG_IDX_W         = 2;

    localparam logic [ADDR_W-1:0]   NET_RESET    = 32'hC0A8_0100;
    localparam logic [PREFIX_W-1:0] PREFIX_RESET = 5'd24;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NETWORK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX  = 2'd1;

    // Operation codes.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_SUCCESS     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_OTHER       = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NONE        = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_DOUBLE_FREE = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_RESERVED    = 3'd5;

endpackage

### rtl/sapa_bitmap.sv
module sapa_bitmap #(
    parameter int WORD_ADDR_W = 3,
    parameter int WORD_W      = 32
) (
    input  logic                   clk,
    input  logic                   rd_en,
    input  logic [WORD_ADDR_W-1:0] rd_addr,
    output logic [WORD_W-1:0]      rd_data,
    input  logic                   wr_en,
    input  logic [WORD_ADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0]      wr_data
);

    localparam int DEPTH = 1 << WORD_ADDR_W;

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/sapa_find_free.sv
module sapa_find_free #(
    parameter int WORD_LG = 5,
    parameter int WORD_W  = 32
) (
    input  logic [WORD_W-1:0]  word,
    input  logic               first,
    input  logic [WORD_LG-1:0] lo_bit,
    input  logic               last,
    input  logic [WORD_LG-1:0] hi_bit,
    output logic               found,
    output logic [WORD_LG-1:0] idx
);

    logic [WORD_W-1:0] lo_mask;
    logic [WORD_W-1:0] hi_mask;
    logic [WORD_W-1:0] free_bits;

    // Only the first word is trimmed below the start and only the last one above the limit.
    assign lo_mask   = first ? ({WORD_W{1'b1}} << lo_bit) : {WORD_W{1'b1}};
    assign hi_mask   = last ? ({WORD_W{1'b1}} >> (~hi_bit)) : {WORD_W{1'b1}};
    assign free_bits = ~word & lo_mask & hi_mask;

    always_comb
    begin
        found = |free_bits;
        idx   = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                idx = WORD_LG'(i);
            end
        end
    end

endmodule

### rtl/subnet_address_pool_allocator_unit.sv
// Channel | Signals                          | Beat contents (lowest bit first)
// s       | s_tvalid s_tready s_tdata s_tuser | tdata: addr[31:0]; tuser: func
// m       | m_tvalid m_tready m_tdata m_tuser | tdata: granted_addr, free_count; tuser: status
// cfg     | cfg_we cfg_index cfg_data         | 0 network_addr, 1 prefix_len
//
// An item goes from decide straight to done when no bitmap access is needed. A direct grant or free
// adds a read and a check; a search repeats read and check for each bitmap word it scans, plus a read
// that ends the scan when no free host is left; the bitmap read port is registered.
// With the default sizing a word holds 32 hosts.
// After reset and after every configuration write the bitmap is cleared, one word per cycle
// (2^MAX_HOST_BITS / 32 words by default), and s_tready stays low meanwhile.
// A result waits in the output register, so a new beat is taken while m is stalled.
module subnet_address_pool_allocator_unit #(
    parameter int MAX_HOST_BITS = sapa_pkg::MAX_HOST_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sapa_pkg::ADDR_W-1:0]        s_tdata,   // addr
    input  logic [0:0]                         s_tuser,   // func
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sapa_pkg::OUT_TDATA_W-1:0]   m_tdata,   // granted_addr[31:0], free_count[39:32]
    output logic [sapa_pkg::STATUS_W-1:0]      m_tuser,   // status
    input  logic                               cfg_we,
    input  logic [sapa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sapa_pkg::ADDR_W-1:0]        cfg_data
);

    import sapa_pkg::*;

    localparam int MHB     = MAX_HOST_BITS;
    localparam int WORD_LG = (MHB > 5) ? 5 : MHB - 1;
    localparam int WORD_W  = 1 << WORD_LG;
    localparam int AW      = MHB - WORD_LG;
    localparam int HBW     = $clog2(MHB + 1);

    localparam logic [MHB-1:0] CAP_MAX = MHB'((1 << MHB) - 3);
    localparam logic [5:0]     P_MIN   = 6'(32 - MHB);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   net_cfg_reg;
    logic [PREFIX_W-1:0] prefix_reg;
    logic                clearing_reg;
    logic [AW-1:0]       clr_cnt_reg;
    logic [MHB-1:0]      used_reg, used_next;

    logic                func_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                search_reg, search_next;
    logic [MHB-1:0]      start_reg, start_next;
    logic [AW:0]         cur_reg, cur_next;
    logic [STATUS_W-1:0] ok_reg, ok_next;
    logic [STATUS_W-1:0] stat_reg, stat_next;
    logic [ADDR_W-1:0]   grant_reg, grant_next;

    logic                m_tvalid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [ADDR_W-1:0]   out_grant_reg;
    logic [FREE_W-1:0]   out_free_reg;

    // Subnet geometry from the configuration registers.
    logic [5:0]        p_clamp;
    logic [5:0]        hb6;
    logic [HBW-1:0]    hb;
    logic [MHB:0]      pow;
    logic [MHB:0]      top_w;
    logic [MHB-1:0]    top;
    logic [MHB-1:0]    lim;
    logic [MHB-1:0]    lim_m1;
    logic [ADDR_W-1:0] net_mask;
    logic [ADDR_W-1:0] net;
    logic [MHB-1:0]    host;
    logic [MHB-1:0]    host_p1;
    logic              in_net;
    logic              reserved;
    logic [AW-1:0]     last_word;

    always_comb
    begin
        p_clamp = {1'b0, prefix_reg};
        if (p_clamp > 6'd30)
        begin
            p_clamp = 6'd30;
        end
        if (p_clamp < P_MIN)
        begin
            p_clamp = P_MIN;
        end
        hb6 = 6'd32 - p_clamp;
        hb  = hb6[HBW-1:0];
    end

    assign pow       = {{MHB{1'b0}}, 1'b1} << hb;
    assign top_w     = pow - {{MHB{1'b0}}, 1'b1};
    assign top       = top_w[MHB-1:0];
    assign lim       = top - MHB'(1);
    assign lim_m1    = top - MHB'(2);
    assign net_mask  = {ADDR_W{1'b1}} << hb;
    assign net       = net_cfg_reg & net_mask;
    assign host      = addr_reg[MHB-1:0] & top;
    assign host_p1   = host + MHB'(1);
    assign in_net    = (addr_reg & net_mask) == net;
    assign reserved  = (host == '0) || (host == lim) || (host == top);
    assign last_word = lim_m1[MHB-1:WORD_LG];

    // Bitmap memory and the free-bit search over one word.
    logic              rd_en;
    logic [WORD_W-1:0] rd_data;
    logic              wr_en;
    logic [WORD_W-1:0] wr_data;
    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [WORD_W-1:0] mem_wr_data;
    logic [WORD_W-1:0] host_onehot;
    logic              host_bit;
    logic              find_first;
    logic              find_last;
    logic              find_found;
    logic [WORD_LG-1:0] find_idx;

    assign mem_wr_en   = clearing_reg | wr_en;
    assign mem_wr_addr = clearing_reg ? clr_cnt_reg : cur_reg[AW-1:0];
    assign mem_wr_data = clearing_reg ? '0 : wr_data;

    sapa_bitmap #(
        .WORD_ADDR_W (AW),
        .WORD_W      (WORD_W)
    ) u_bitmap (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (cur_reg[AW-1:0]),
        .rd_data (rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    assign find_first = cur_reg == {1'b0, start_reg[MHB-1:WORD_LG]};
    assign find_last  = cur_reg == {1'b0, last_word};

    sapa_find_free #(
        .WORD_LG (WORD_LG),
        .WORD_W  (WORD_W)
    ) u_find (
        .word   (rd_data),
        .first  (find_first),
        .lo_bit (start_reg[WORD_LG-1:0]),
        .last   (find_last),
        .hi_bit (lim_m1[WORD_LG-1:0]),
        .found  (find_found),
        .idx    (find_idx)
    );

    assign host_onehot = {{(WORD_W-1){1'b0}}, 1'b1} << host[WORD_LG-1:0];
    assign host_bit    = |(rd_data & host_onehot);

    // Free count after the operation.
    logic [MHB-1:0]    cap;
    logic [MHB-1:0]    free_n;
    logic [FREE_W-1:0] free_sat;

    assign cap      = top - MHB'(3) + MHB'(1);
    assign free_n   = (used_reg <= cap) ? cap - used_reg : '0;
    assign free_sat = (free_n > MHB'(255)) ? 8'd255 : 8'(free_n);

    logic accept;
    logic out_load;

    assign s_tready = (state_reg == ST_IDLE) && !clearing_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        search_next = search_reg;
        start_next  = start_reg;
        cur_next    = cur_reg;
        ok_next     = ok_reg;
        stat_next   = stat_reg;
        grant_next  = grant_reg;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        wr_data     = rd_data;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                grant_next = '0;
                if (func_reg == FUNC_ALLOC)
                begin
                    if (addr_reg == '0 || (in_net && reserved))
                    begin
                        search_next = 1'b1;
                        start_next  = MHB'(1);
                        cur_next    = '0;
                        ok_next     = (addr_reg == '0) ? STAT_SUCCESS : STAT_OTHER;
                        state_next  = ST_READ;
                    end
                    else if (!in_net)
                    begin
                        stat_next  = STAT_NONE;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        search_next = 1'b0;
                        cur_next    = {1'b0, host[MHB-1:WORD_LG]};
                        state_next  = ST_READ;
                    end
                end
                else if (!in_net)
                begin
                    stat_next  = STAT_NOT_FOUND;
                    state_next = ST_DONE;
                end
                else if (reserved)
                begin
                    stat_next  = STAT_RESERVED;
                    state_next = ST_DONE;
                end
                else
                begin
                    search_next = 1'b0;
                    cur_next    = {1'b0, host[MHB-1:WORD_LG]};
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                if (search_reg && (cur_reg > {1'b0, last_word}))
                begin
                    stat_next  = STAT_NONE;
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!search_reg)
                begin
                    if (func_reg == FUNC_ALLOC)
                    begin
                        if (!host_bit)
                        begin
                            wr_en      = 1'b1;
                            wr_data    = rd_data | host_onehot;
                            used_next  = used_reg + MHB'(1);
                            stat_next  = STAT_SUCCESS;
                            grant_next = net | ADDR_W'(host);
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            // Requested host is taken: scan upward from the next one.
                            search_next = 1'b1;
                            start_next  = host_p1;
                            cur_next    = {1'b0, host_p1[MHB-1:WORD_LG]};
                            ok_next     = STAT_OTHER;
                            state_next  = ST_READ;
                        end
                    end
                    else
                    begin
                        if (host_bit)
                        begin
                            wr_en     = 1'b1;
                            wr_data   = rd_data & ~host_onehot;
                            if (used_reg != '0)
                            begin
                                used_next = used_reg - MHB'(1);
                            end
                            stat_next = STAT_SUCCESS;
                        end
                        else
                        begin
                            stat_next = STAT_DOUBLE_FREE;
                        end
                        state_next = ST_DONE;
                    end
                end
                else if (find_found)
                begin
                    wr_en      = 1'b1;
                    wr_data    = rd_data | ({{(WORD_W-1){1'b0}}, 1'b1} << find_idx);
                    used_next  = used_reg + MHB'(1);
                    stat_next  = ok_reg;
                    grant_next = net | ADDR_W'({cur_reg[AW-1:0], find_idx});
                    state_next = ST_DONE;
                end
                else
                begin
                    cur_next   = cur_reg + (AW+1)'(1);
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    logic cfg_hit;

    assign cfg_hit = cfg_we && ((cfg_index == CFG_NETWORK) || (cfg_index == CFG_PREFIX));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            net_cfg_reg  <= NET_RESET;
            prefix_reg   <= PREFIX_RESET;
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            used_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= cfg_hit ? '0 : used_next;
            if (cfg_hit)
            begin
                if (cfg_index == CFG_NETWORK)
                begin
                    net_cfg_reg <= cfg_data;
                end
                else
                begin
                    prefix_reg <= cfg_data[PREFIX_W-1:0];
                end
                clearing_reg <= 1'b1;
                clr_cnt_reg  <= '0;
            end
            else if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == {AW{1'b1}})
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= s_tuser[0];
            addr_reg <= s_tdata;
        end
        search_reg <= search_next;
        start_reg  <= start_next;
        cur_reg    <= cur_next;
        ok_reg     <= ok_next;
        stat_reg   <= stat_next;
        grant_reg  <= grant_next;
        if (out_load)
        begin
            out_status_reg <= stat_reg;
            out_grant_reg  <= grant_reg;
            out_free_reg   <= free_sat;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_free_reg, out_grant_reg};

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CAP_MAX)
        else $error("used count exceeds pool capacity");

    a_check_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> ($past(state_reg) == ST_READ))
        else $error("word checked without a preceding read");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside the done state");

    a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_DECIDE))
        else $error("accepted beat did not start a decision");

    a_used_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(used_reg) |-> ($past(state_reg) == ST_CHECK) || $past(cfg_we))
        else $error("used count changed outside a bitmap update");

endmodule

### dv/subnet_address_pool_allocator_unit_tb.sv
module subnet_address_pool_allocator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sapa_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int RUN_LIMIT_CYCLES = 500_000;
    localparam int DRAIN_CYCLES     = 24;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int POOL_HOSTS       = 1 << MAX_HOST_BITS_DEF;

    // Indexes past the register list; writes there must leave the pool alone.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   granted;
        logic [FREE_W-1:0]   free_cnt;
    } pool_result_t;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
        bit                typed;
        pool_result_t      want;
    } request_row_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   net;
        bit                  rand_net;
        logic [PREFIX_W-1:0] prefix;
        bit [9:0]            items;
        bit [6:0]            alloc_pct;
        bit                  spare_writes;
        bit                  squeeze;
    } pool_setting_t;

    localparam int NUM_REQ_ROWS = 22;
    localparam request_row_t REQ_ROWS [NUM_REQ_ROWS] = '{
        '{FUNC_ALLOC, 32'h0000_0000, 1'b1, '{STAT_SUCCESS,     32'hC0A8_0101, 8'd252}},
        '{FUNC_ALLOC, 32'hC0A8_0101, 1'b1, '{STAT_OTHER,       32'hC0A8_0102, 8'd251}},
        '{FUNC_ALLOC, 32'hC0A8_0100, 1'b1, '{STAT_OTHER,       32'hC0A8_0103, 8'd250}},
        '{FUNC_ALLOC, 32'hC0A8_01FF, 1'b1, '{STAT_OTHER,       32'hC0A8_0104, 8'd249}},
        '{FUNC_ALLOC, 32'hC0A8_01FE, 1'b1, '{STAT_OTHER,       32'hC0A8_0105, 8'd248}},
        '{FUNC_ALLOC, 32'h0A00_0001, 1'b1, '{STAT_NONE,        32'h0000_0000, 8'd248}},
        '{FUNC_ALLOC, 32'hC0A8_01FD, 1'b1, '{STAT_SUCCESS,     32'hC0A8_01FD, 8'd247}},
        '{FUNC_ALLOC, 32'hC0A8_01FD, 1'b1, '{STAT_NONE,        32'h0000_0000, 8'd247}},
        '{FUNC_FREE,  32'hC0A8_01FD, 1'b1, '{STAT_SUCCESS,     32'h0000_0000, 8'd248}},
        '{FUNC_FREE,  32'hC0A8_01FD, 1'b1, '{STAT_DOUBLE_FREE, 32'h0000_0000, 8'd248}},
        '{FUNC_FREE,  32'hC0A8_0100, 1'b1, '{STAT_RESERVED,    32'h0000_0000, 8'd248}},
        '{FUNC_FREE,  32'hC0A8_01FF, 1'b1, '{STAT_RESERVED,    32'h0000_0000, 8'd248}},
        '{FUNC_FREE,  32'hC0A8_01FE, 1'b1, '{STAT_RESERVED,    32'h0000_0000, 8'd248}},
        '{FUNC_FREE,  32'h0A00_0001, 1'b1, '{STAT_NOT_FOUND,   32'h0000_0000, 8'd248}},
        '{FUNC_FREE,  32'hFFFF_FFFF, 1'b1, '{STAT_NOT_FOUND,   32'h0000_0000, 8'd248}},
        '{FUNC_ALLOC, 32'hFFFF_FFFF, 1'b1, '{STAT_NONE,        32'h0000_0000, 8'd248}},
        '{FUNC_FREE,  32'h0000_0000, 1'b1, '{STAT_NOT_FOUND,   32'h0000_0000, 8'd248}},
        '{FUNC_ALLOC, 32'hC0A8_0180, 1'b0, '0},
        '{FUNC_ALLOC, 32'hC0A8_0180, 1'b0, '0},
        '{FUNC_FREE,  32'hC0A8_0103, 1'b0, '0},
        '{FUNC_ALLOC, 32'h0000_0000, 1'b0, '0},
        '{FUNC_ALLOC, 32'hC0A8_0102, 1'b0, '0}
    };

    localparam int NUM_SETTINGS = 8;
    localparam pool_setting_t SETTINGS_LIST [NUM_SETTINGS] = '{
        '{32'hC0A8_0100, 1'b0, 5'd24, 10'd300, 7'd85, 1'b0, 1'b0},
        '{32'h0A00_0000, 1'b0, 5'd30, 10'd60,  7'd60, 1'b0, 1'b0},
        '{32'h0000_0000, 1'b0, 5'd24, 10'd100, 7'd60, 1'b1, 1'b0},
        '{32'hFFFF_FFFF, 1'b0, 5'd31, 10'd60,  7'd55, 1'b0, 1'b0},
        '{32'h0000_0000, 1'b1, 5'd0,  10'd120, 7'd70, 1'b0, 1'b0},
        '{32'h0000_0000, 1'b1, 5'd28, 10'd80,  7'd60, 1'b1, 1'b1},
        '{32'h0000_0000, 1'b1, 5'd27, 10'd70,  7'd50, 1'b0, 1'b0},
        '{32'hAC10_0040, 1'b0, 5'd26, 10'd60,  7'd65, 1'b0, 1'b0}
    };

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [ADDR_W-1:0]      s_tdata   = '0;
    logic [0:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]    m_tuser;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [ADDR_W-1:0]      cfg_data  = '0;

    // Shadow copy of the pool and its registers.
    logic [ADDR_W-1:0]   net_reg;
    logic [PREFIX_W-1:0] prefix_reg;
    bit                  host_busy [POOL_HOSTS];
    int unsigned         hosts_in_use;

    pool_result_t pending_results [$];
    int           mismatch_count = 0;
    int           results_seen   = 0;
    int           items_sent     = 0;
    int           burst_left     = 0;
    bit           hold_req       = 1'b0;

    subnet_address_pool_allocator_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic void clear_pool();
        foreach (host_busy[h])
            host_busy[h] = 1'b0;
        hosts_in_use = 0;
    endfunction

    // Out-of-range prefixes saturate so the host field stays 2 to 8 bits wide.
    function automatic int unsigned host_bit_count();
        int unsigned p;
        p = prefix_reg;
        if (p > 30)
            p = 30;
        if (p < ADDR_W - MAX_HOST_BITS_DEF)
            p = ADDR_W - MAX_HOST_BITS_DEF;
        return ADDR_W - p;
    endfunction

    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
        if (idx == CFG_NETWORK)
        begin
            net_reg = val;
            clear_pool();
        end
        else if (idx == CFG_PREFIX)
        begin
            prefix_reg = val[PREFIX_W-1:0];
            clear_pool();
        end
    endfunction

    function automatic bit claim_free(int unsigned start, int unsigned limit,
                                      output int unsigned got);
        got = 0;
        for (int unsigned h = start; h < limit; h++)
        begin
            if (!host_busy[h])
            begin
                host_busy[h] = 1'b1;
                hosts_in_use++;
                got = h;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic pool_result_t allocate_or_release(logic op, logic [ADDR_W-1:0] a);
        int unsigned  hb;
        int unsigned  top;
        int unsigned  host;
        int unsigned  got;
        int unsigned  cap;
        int unsigned  free_n;
        logic [ADDR_W-1:0] mask;
        bit           in_net;
        bit           rsvd;
        pool_result_t r;
        hb     = host_bit_count();
        top    = (1 << hb) - 1;
        mask   = 32'hFFFF_FFFF << hb;
        host   = a & top;
        in_net = (a & mask) == (net_reg & mask);
        rsvd   = (host == 0) || (host >= top - 1);
        r      = '0;
        got    = 0;
        if (op == FUNC_ALLOC)
        begin
            if (a == '0)
                r.status = claim_free(1, top - 1, got) ? STAT_SUCCESS : STAT_NONE;
            else if (!in_net)
                r.status = STAT_NONE;
            else if (rsvd)
                r.status = claim_free(1, top - 1, got) ? STAT_OTHER : STAT_NONE;
            else if (!host_busy[host])
            begin
                host_busy[host] = 1'b1;
                hosts_in_use++;
                got = host;
                r.status = STAT_SUCCESS;
            end
            else
                r.status = claim_free(host + 1, top - 1, got) ? STAT_OTHER : STAT_NONE;
            if (r.status == STAT_SUCCESS || r.status == STAT_OTHER)
                r.granted = (net_reg & mask) | got;
        end
        else
        begin
            if (!in_net)
                r.status = STAT_NOT_FOUND;
            else if (rsvd)
                r.status = STAT_RESERVED;
            else if (!host_busy[host])
                r.status = STAT_DOUBLE_FREE;
            else
            begin
                host_busy[host] = 1'b0;
                if (hosts_in_use > 0)
                    hosts_in_use--;
                r.status = STAT_SUCCESS;
            end
        end
        cap    = top - 2;
        free_n = (hosts_in_use <= cap) ? cap - hosts_in_use : 0;
        r.free_cnt = (free_n > 255) ? 8'd255 : free_n[FREE_W-1:0];
        return r;
    endfunction

    function automatic int unsigned busy_host_near(int unsigned from, int unsigned top);
        int unsigned h;
        for (int unsigned k = 0; k <= top; k++)
        begin
            h = (from + k) & top;
            if (host_busy[h])
                return h;
        end
        return from;
    endfunction

    // Most requests land inside the subnet so the pool really fills and drains;
    // the rest are any-host requests, near misses on the network bits and noise.
    task automatic random_request(input int unsigned alloc_pct, output logic op,
                                  output logic [ADDR_W-1:0] a);
        int unsigned hb;
        int unsigned top;
        int unsigned h;
        int unsigned roll;
        logic [ADDR_W-1:0] base;
        hb   = host_bit_count();
        top  = (1 << hb) - 1;
        base = net_reg & (32'hFFFF_FFFF << hb);
        op   = ($urandom_range(99) < alloc_pct) ? FUNC_ALLOC : FUNC_FREE;
        h    = $urandom_range(top);
        if (op == FUNC_FREE && $urandom_range(3) != 0)
            h = busy_host_near(h, top);
        roll = $urandom_range(99);
        if (roll < 8)
            a = $urandom;
        else if (roll < 14)
            a = (base | h) ^ (32'h1 << $urandom_range(ADDR_W - 1, hb));
        else if (roll < 24 && op == FUNC_ALLOC)
            a = '0;
        else
            a = base | h;
    endtask

    task automatic push_request(input logic op, input logic [ADDR_W-1:0] a, input bit typed,
                                input pool_result_t want);
        pool_result_t predicted;
        int unsigned  gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= a;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = allocate_or_release(op, a);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(24);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 1);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                s_tdata  <= $urandom;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        apply_reg_write(idx, val);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        pool_setting_t     cur;
        logic              op;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] pdata;
        net_reg    = NET_RESET;
        prefix_reg = PREFIX_RESET;
        clear_pool();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_REQ_ROWS; i++)
            push_request(REQ_ROWS[i].op, REQ_ROWS[i].addr, REQ_ROWS[i].typed, REQ_ROWS[i].want);

        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            cur = SETTINGS_LIST[s];
            s_tvalid <= 1'b0;
            wait_drained();
            write_reg(CFG_NETWORK, cur.rand_net ? 32'($urandom) : cur.net);
            // Upper data bits above the prefix field are don't-care.
            pdata = ($urandom_range(1) != 0) ? ((32'($urandom) & 32'hFFFF_FFE0) | cur.prefix)
                                              : 32'(cur.prefix);
            write_reg(CFG_PREFIX, pdata);
            if (cur.spare_writes)
            begin
                write_reg(CFG_SPARE_A, $urandom);
                write_reg(CFG_SPARE_B, $urandom);
            end
            cfg_we <= 1'b0;
            if (cur.squeeze)
                hold_req = 1'b1;
            for (int n = 0; n < cur.items; n++)
            begin
                random_request(cur.alloc_pct, op, a);
                push_request(op, a, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        wait_drained();
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            mismatch_count++;
        end
        $display("Sent %0d request beats (%0d table rows) over %0d pool settings plus reset.",
                 items_sent, NUM_REQ_ROWS, NUM_SETTINGS);
        $display("Checked %0d result beats; %0d mismatches.", results_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: changing stall patterns, plus one long hold-off on request
    // so the output register fills and the block has to stall its input.
    initial
    begin : result_sink
        int unsigned mode;
        int unsigned span;
        int unsigned tick;
        mode = 0;
        span = 0;
        tick = 0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(3);
                    span = $urandom_range(80, 10);
                end
                span--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(1);
                    2:       m_tready <= (tick % 4 == 0);
                    default: m_tready <= ($urandom_range(9) < 8);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        pool_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat: status %0d, granted_addr %h",
                       m_tuser, m_tdata[ADDR_W-1:0]);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[ADDR_W-1:0] !== want.granted)
                begin
                    $error("granted_addr: expected %h, got %h", want.granted,
                           m_tdata[ADDR_W-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[ADDR_W +: FREE_W] !== want.free_cnt)
                begin
                    $error("free_count: expected %0d, got %0d", want.free_cnt,
                           m_tdata[ADDR_W +: FREE_W]);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        #(RUN_LIMIT_CYCLES * CLK_PERIOD);
        $display("Timeout with %0d results outstanding.", pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
